// ===== sv/vsa_pkg.sv =====
`default_nettype none
package vsa_pkg;
  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BAD_SIZE = 3'd1, ST_NO_SLOTS = 3'd2,
    ST_NO_BUFFERS = 3'd3, ST_BAD_SLOT = 3'd4
  } status_e;
  typedef enum logic [1:0] {MODE_GET = 2'd0, MODE_REL = 2'd1} mode_e;
  localparam int unsigned RoundMask = 31;
  localparam int unsigned Gran = 32;
  localparam logic [15:0] MinBufReset = 16'd8192;
endpackage
`default_nettype wire

// ===== sv/vsa_ram.sv =====
`default_nettype none
module vsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/vertex_slot_allocator_core.sv =====
// busy_o stays high from the accept edge until the result is emitted: for an item rejected at
// accept, for a release, for a free-list hit and for a get that walks
// every buffer of its format and then opens a new one.
// done_o follows in the cycle after the last busy cycle, when the next item can already be accepted.
// After reset a clearing pass over all NUM_FORMATS * NUM_SIZE_CLASSES entries empties
// the free-list head RAM with busy_o high. The receiver cannot stall.
`default_nettype none
module vertex_slot_allocator_core #(
  parameter int unsigned NUM_FORMATS      = 18,
  parameter int unsigned NUM_SIZE_CLASSES = 128,
  parameter int unsigned NUM_SLOTS        = 4096,
  parameter int unsigned NUM_BUFFERS      = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        mode_i,
  input  wire logic [4:0]  format_i,
  input  wire logic [12:0] request_size_i,
  input  wire logic [11:0] slot_index_i,
  output      logic        done_o,
  output      logic [2:0]  status_o,
  output      logic        reused_o,
  output      logic [11:0] granted_slot_o,
  output      logic [4:0]  granted_buffer_o,
  output      logic [15:0] slot_offset_o,
  output      logic [12:0] rounded_size_o
);
  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned SL = SW + 1;
  localparam int unsigned BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned BL = $clog2(NUM_BUFFERS + 1);
  localparam int unsigned FW = (NUM_FORMATS > 1) ? $clog2(NUM_FORMATS) : 1;
  localparam int unsigned CW = (NUM_SIZE_CLASSES > 1) ? $clog2(NUM_SIZE_CLASSES) : 1;
  localparam int unsigned NL = NUM_FORMATS * NUM_SIZE_CLASSES;
  localparam int unsigned LW = (NL > 1) ? $clog2(NL) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RREAD, S_RWAIT, S_RPUSH, S_GHEAD, S_GHWAIT, S_GPOP,
    S_WREAD, S_WWAIT, S_WCHK, S_OPEN, S_CARVE, S_SREAD, S_SWAIT, S_EMIT
  } state_e;

  state_e st_q, st_d;
  logic [15:0] minbuf_q;
  logic [LW-1:0] clr_q;
  logic [SL-1:0] slots_used_q;
  logic [BL-1:0] bufs_used_q;
  logic [BL-1:0] fmt_heads_q [NUM_FORMATS];
  logic [FW-1:0] fmt_q;
  logic [12:0]   size_q;
  logic [LW-1:0] list_q;
  logic [SW-1:0] slot_q;
  logic [BL-1:0] b_q;
  logic [BL-1:0] walk_n_q;
  logic          reused_q;
  logic [2:0]    err_q;

  // RAM ports
  logic fh_we, sz_we, of_we, sb_we, lk_we, bf_we, bc_we, bfm_we, bl_we;
  logic [LW-1:0] fh_wa, fh_ra;
  logic [SL-1:0] fh_wd, fh_rd, lk_wd, lk_rd;
  logic [SW-1:0] s_wa, s_ra;
  logic [12:0] sz_wd, sz_rd;
  logic [15:0] of_wd, of_rd;
  logic [BW-1:0] sb_wd, sb_rd, b_wa, b_ra;
  logic [16:0] bf_wd, bf_rd, bc_wd, bc_rd;
  logic [FW-1:0] bfm_rd;
  logic [BL-1:0] bl_wd, bl_rd;

  vsa_ram #(.Width(SL), .Depth(NL)) u_fh (.clk_i, .we_i(fh_we), .waddr_i(fh_wa),
    .wdata_i(fh_wd), .raddr_i(fh_ra), .rdata_o(fh_rd));
  vsa_ram #(.Width(13), .Depth(NUM_SLOTS)) u_sz (.clk_i, .we_i(sz_we), .waddr_i(s_wa),
    .wdata_i(sz_wd), .raddr_i(s_ra), .rdata_o(sz_rd));
  vsa_ram #(.Width(16), .Depth(NUM_SLOTS)) u_of (.clk_i, .we_i(of_we), .waddr_i(s_wa),
    .wdata_i(of_wd), .raddr_i(s_ra), .rdata_o(of_rd));
  vsa_ram #(.Width(BW), .Depth(NUM_SLOTS)) u_sb (.clk_i, .we_i(sb_we), .waddr_i(s_wa),
    .wdata_i(sb_wd), .raddr_i(s_ra), .rdata_o(sb_rd));
  vsa_ram #(.Width(SL), .Depth(NUM_SLOTS)) u_lk (.clk_i, .we_i(lk_we), .waddr_i(s_wa),
    .wdata_i(lk_wd), .raddr_i(s_ra), .rdata_o(lk_rd));
  vsa_ram #(.Width(17), .Depth(NUM_BUFFERS)) u_bf (.clk_i, .we_i(bf_we), .waddr_i(b_wa),
    .wdata_i(bf_wd), .raddr_i(b_ra), .rdata_o(bf_rd));
  vsa_ram #(.Width(17), .Depth(NUM_BUFFERS)) u_bc (.clk_i, .we_i(bc_we), .waddr_i(b_wa),
    .wdata_i(bc_wd), .raddr_i(b_ra), .rdata_o(bc_rd));
  vsa_ram #(.Width(FW), .Depth(NUM_BUFFERS)) u_bfm (.clk_i, .we_i(bfm_we), .waddr_i(b_wa),
    .wdata_i(fmt_q), .raddr_i(sb_rd), .rdata_o(bfm_rd));
  vsa_ram #(.Width(BL), .Depth(NUM_BUFFERS)) u_bl (.clk_i, .we_i(bl_we), .waddr_i(b_wa),
    .wdata_i(bl_wd), .raddr_i(b_ra), .rdata_o(bl_rd));

  logic [13:0] rnd;
  logic [8:0]  cls_raw;
  logic        get_bad;
  logic [16:0] room;
  logic        fits;
  logic [LW-1:0] rel_list;
  logic [16:0] cap;

  always_comb begin
    rnd = ({1'b0, request_size_i} + 14'(vsa_pkg::RoundMask)) & ~14'(vsa_pkg::RoundMask);
    cls_raw = 9'(rnd >> 5) - 9'd1;
    get_bad = (32'(format_i) >= NUM_FORMATS) || (rnd == 14'd0) ||
              (32'(cls_raw) >= NUM_SIZE_CLASSES);
    room = bc_rd - bf_rd;
    fits = room >= 17'(size_q);
    rel_list = LW'(32'(bfm_rd) * NUM_SIZE_CLASSES + 32'(sz_rd[12:5]) - 32'd1);
    cap = (minbuf_q > 16'(size_q)) ? 17'(minbuf_q) : 17'(size_q);
  end

  always_comb begin
    st_d = st_q;
    fh_we = 1'b0; fh_wa = list_q; fh_wd = SL'(NUM_SLOTS); fh_ra = list_q;
    sz_we = 1'b0; of_we = 1'b0; sb_we = 1'b0; lk_we = 1'b0;
    s_wa = SW'(slots_used_q); s_ra = slot_q;
    sz_wd = size_q; of_wd = bf_rd[15:0]; sb_wd = BW'(b_q); lk_wd = SL'(NUM_SLOTS);
    bf_we = 1'b0; bc_we = 1'b0; bfm_we = 1'b0; bl_we = 1'b0;
    b_wa = BW'(b_q); b_ra = BW'(b_q);
    bf_wd = bf_rd + 17'(size_q); bc_wd = cap; bl_wd = fmt_heads_q[fmt_q];
    case (st_q)
      S_CLR: begin
        fh_we = 1'b1; fh_wa = clr_q;
        if (32'(clr_q) == NL - 1) st_d = S_IDLE;
      end
      S_IDLE: begin
        s_ra = SW'(slot_index_i);
        if (start_i) begin
          if (mode_i) begin
            st_d = (32'(slot_index_i) >= 32'(slots_used_q) ||
                    32'(slot_index_i) >= NUM_SLOTS) ? S_EMIT : S_RREAD;
          end else begin
            st_d = get_bad ? S_EMIT : S_GHEAD;
          end
        end
      end
      S_RREAD: st_d = S_RWAIT;
      S_RWAIT: begin fh_ra = rel_list; st_d = S_RPUSH; end
      S_RPUSH: begin
        st_d = S_EMIT;
      end
      S_GHEAD: st_d = S_GHWAIT;
      S_GHWAIT: st_d = S_GPOP;
      S_GPOP: begin
        if (32'(fh_rd) < NUM_SLOTS) st_d = S_SREAD;
        else if (32'(slots_used_q) >= NUM_SLOTS) st_d = S_EMIT;
        else if (32'(fmt_heads_q[fmt_q]) < NUM_BUFFERS) st_d = S_WREAD;
        else st_d = S_OPEN;
      end
      S_SREAD: st_d = S_SWAIT;
      S_SWAIT: begin
        if (reused_q) begin
          fh_we = 1'b1; fh_wd = lk_rd;
        end
        st_d = S_EMIT;
      end
      S_WREAD: st_d = S_WWAIT;
      S_WWAIT: st_d = S_WCHK;
      S_WCHK: begin
        if (fits) st_d = S_CARVE;
        else if (32'(bl_rd) < NUM_BUFFERS && 32'(walk_n_q) + 1 < NUM_BUFFERS)
          st_d = S_WREAD;
        else st_d = S_OPEN;
      end
      S_OPEN: begin
        if (32'(bufs_used_q) < NUM_BUFFERS) begin
          b_wa = BW'(bufs_used_q);
          bc_we = 1'b1; bfm_we = 1'b1; bl_we = 1'b1;
          bf_we = 1'b1; bf_wd = 17'(size_q);
          sz_we = 1'b1; of_we = 1'b1; sb_we = 1'b1; lk_we = 1'b1;
          of_wd = 16'd0; sb_wd = BW'(bufs_used_q);
          st_d = S_SREAD;
        end else st_d = S_EMIT;
      end
      S_CARVE: begin
        bf_we = 1'b1;
        sz_we = 1'b1; of_we = 1'b1; sb_we = 1'b1; lk_we = 1'b1;
        st_d = S_SREAD;
      end
      S_EMIT: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
    if (st_q == S_RPUSH) begin
      fh_we = 1'b1; fh_wd = SL'(slot_q);
      lk_we = 1'b1; s_wa = slot_q; lk_wd = fh_rd;
    end
  end

  logic rel_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR;
      clr_q <= '0;
      minbuf_q <= vsa_pkg::MinBufReset;
      slots_used_q <= '0;
      bufs_used_q <= '0;
      for (int i = 0; i < NUM_FORMATS; i++) fmt_heads_q[i] <= BL'(NUM_BUFFERS);
      done_o <= 1'b0;
    end else begin
      st_q <= st_d;
      done_o <= (st_q == S_EMIT);
      if (cfg_we_i) minbuf_q <= cfg_wdata_i;
      if (st_q == S_CLR) clr_q <= clr_q + LW'(1);
      if (st_q == S_OPEN && st_d == S_SREAD) begin
        bufs_used_q <= bufs_used_q + BL'(1);
        fmt_heads_q[fmt_q] <= bufs_used_q;
      end
      if ((st_q == S_OPEN && st_d == S_SREAD) || st_q == S_CARVE)
        slots_used_q <= slots_used_q + SL'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        fmt_q <= FW'(format_i);
        size_q <= rnd[12:0];
        list_q <= LW'(32'(format_i) * NUM_SIZE_CLASSES + 32'(cls_raw));
        slot_q <= SW'(slot_index_i);
        rel_q <= mode_i;
        reused_q <= 1'b0;
        walk_n_q <= '0;
        err_q <= mode_i ? vsa_pkg::ST_BAD_SLOT : vsa_pkg::ST_BAD_SIZE;
      end
      S_RWAIT: list_q <= rel_list;
      S_RPUSH: err_q <= vsa_pkg::ST_OK;
      S_GPOP: begin
        b_q <= fmt_heads_q[fmt_q];
        if (32'(fh_rd) < NUM_SLOTS) begin
          slot_q <= SW'(fh_rd); reused_q <= 1'b1; err_q <= vsa_pkg::ST_OK;
        end else if (32'(slots_used_q) >= NUM_SLOTS) err_q <= vsa_pkg::ST_NO_SLOTS;
      end
      S_WCHK: begin
        if (!fits) begin
          b_q <= bl_rd;
          walk_n_q <= walk_n_q + BL'(1);
        end
      end
      S_OPEN: begin
        err_q <= (32'(bufs_used_q) < NUM_BUFFERS) ? vsa_pkg::ST_OK : vsa_pkg::ST_NO_BUFFERS;
        slot_q <= SW'(slots_used_q);
      end
      S_CARVE: begin slot_q <= SW'(slots_used_q); err_q <= vsa_pkg::ST_OK; end
      S_SWAIT: begin
        granted_slot_o <= 12'(slot_q);
        granted_buffer_o <= 5'(sb_rd);
        slot_offset_o <= of_rd;
        rounded_size_o <= sz_rd;
      end
      default: ;
    endcase
    if (st_q == S_RPUSH) begin
      granted_slot_o <= 12'(slot_q);
      granted_buffer_o <= 5'(sb_rd);
      slot_offset_o <= of_rd;
      rounded_size_o <= sz_rd;
    end
    if (st_q == S_EMIT) begin
      status_o <= err_q;
      reused_o <= reused_q & (err_q == vsa_pkg::ST_OK) & ~rel_q;
      if (err_q != vsa_pkg::ST_OK) begin
        granted_slot_o <= '0; granted_buffer_o <= '0;
        slot_offset_o <= '0; rounded_size_o <= '0;
      end
    end
  end

  assign busy_o = (st_q != S_IDLE);

  a_done_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(st_q == S_EMIT)) else $error("done without emit");
  a_slots_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slots_used_q) <= NUM_SLOTS) else $error("slot count overflow");
  a_bufs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bufs_used_q) <= NUM_BUFFERS) else $error("buffer count overflow");
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int unsigned NFMT  = 18;
  localparam int unsigned NCLS  = 128;
  localparam int unsigned NSLOT = 4096;
  localparam int unsigned NBUF  = 32;
  localparam int unsigned SETTLE = 150;
  localparam logic GET = 1'(vsa_pkg::MODE_GET);
  localparam logic REL = 1'(vsa_pkg::MODE_REL);
  localparam logic [2:0] StOk = vsa_pkg::ST_OK;
  localparam logic [2:0] StBadSize = vsa_pkg::ST_BAD_SIZE;
  localparam logic [2:0] StNoSlots = vsa_pkg::ST_NO_SLOTS;
  localparam logic [2:0] StNoBufs = vsa_pkg::ST_NO_BUFFERS;
  localparam logic [2:0] StBadSlot = vsa_pkg::ST_BAD_SLOT;

  typedef struct packed {
    logic [2:0]  status;
    logic        reused;
    logic [11:0] slot;
    logic [4:0]  bufid;
    logic [15:0] offset;
    logic [12:0] size;
  } alloc_res_t;

  typedef struct packed {
    logic        mode;
    logic [4:0]  fmt;
    logic [12:0] req;
    logic [11:0] sidx;
    logic        typed;
    alloc_res_t  res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        mode_i = 1'b0;
  logic [4:0]  format_i = '0;
  logic [12:0] request_size_i = '0;
  logic [11:0] slot_index_i = '0;
  logic        busy_o, done_o, reused_o;
  logic [2:0]  status_o;
  logic [11:0] granted_slot_o;
  logic [4:0]  granted_buffer_o;
  logic [15:0] slot_offset_o;
  logic [12:0] rounded_size_o;

  vertex_slot_allocator_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_wdata_i,
    .mode_i, .format_i, .request_size_i, .slot_index_i,
    .done_o, .status_o, .reused_o, .granted_slot_o, .granted_buffer_o,
    .slot_offset_o, .rounded_size_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned free_head [NFMT*NCLS];
  int unsigned slot_size [NSLOT];
  int unsigned slot_off [NSLOT];
  int unsigned slot_bufid [NSLOT];
  int unsigned slot_next [NSLOT];
  int unsigned buf_fill [NBUF];
  int unsigned buf_cap [NBUF];
  int unsigned buf_fmt [NBUF];
  int unsigned buf_next [NBUF];
  int unsigned fmt_newest [NFMT];
  int unsigned slots_carved, bufs_opened, min_cap;

  alloc_res_t pending_grants[$];
  int unsigned errors, items_sent, results_seen;
  int unsigned status_hits [5];

  function automatic alloc_res_t slot_grant(int unsigned s, logic reuse);
    alloc_res_t r;
    r.status = StOk;
    r.reused = reuse;
    r.slot   = s[11:0];
    r.bufid  = slot_bufid[s][4:0];
    r.offset = slot_off[s][15:0];
    r.size   = slot_size[s][12:0];
    return r;
  endfunction

  function automatic int unsigned carve_slot(int unsigned b, int unsigned sz);
    int unsigned s;
    s = slots_carved;
    slot_size[s] = sz;
    slot_off[s] = buf_fill[b];
    slot_bufid[s] = b;
    slot_next[s] = NSLOT;
    buf_fill[b] += sz;
    slots_carved++;
    return s;
  endfunction

  function automatic alloc_res_t predict_alloc(logic m, logic [4:0] f, logic [12:0] rq,
                                               logic [11:0] si);
    int unsigned sz, cls, lst, b, n, s;
    alloc_res_t r;
    r = '0;
    if (m == REL) begin
      if (si >= slots_carved) begin
        r.status = StBadSlot;
        return r;
      end
      lst = buf_fmt[slot_bufid[si]] * NCLS + slot_size[si] / 32 - 1;
      slot_next[si] = free_head[lst];
      free_head[lst] = si;
      return slot_grant(si, 1'b0);
    end
    sz = (rq + 31) & ~32'd31;
    cls = sz / 32 - 1;
    if (f >= NFMT || sz == 0 || cls >= NCLS) begin
      r.status = StBadSize;
      return r;
    end
    lst = f * NCLS + cls;
    s = free_head[lst];
    if (s < NSLOT) begin
      free_head[lst] = slot_next[s];
      return slot_grant(s, 1'b1);
    end
    if (slots_carved >= NSLOT) begin
      r.status = StNoSlots;
      return r;
    end
    b = fmt_newest[f];
    for (n = 0; n < NBUF && b < NBUF; n++) begin
      if (buf_cap[b] - buf_fill[b] >= sz) return slot_grant(carve_slot(b, sz), 1'b0);
      b = buf_next[b];
    end
    if (bufs_opened >= NBUF) begin
      r.status = StNoBufs;
      return r;
    end
    b = bufs_opened++;
    buf_cap[b] = (min_cap > sz) ? min_cap : sz;
    buf_fill[b] = 0;
    buf_fmt[b] = f;
    buf_next[b] = fmt_newest[f];
    fmt_newest[f] = b;
    return slot_grant(carve_slot(b, sz), 1'b0);
  endfunction

  task automatic report(string field, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    alloc_res_t w;
    if (rst_ni && done_o) begin
      results_seen++;
      if (status_o <= StBadSlot) status_hits[status_o]++;
      if (pending_grants.size() == 0) begin
        $display("[%0t] result with no item outstanding", $time);
        errors++;
      end else begin
        w = pending_grants.pop_front();
        if (status_o !== w.status) report("status", status_o, w.status);
        if (reused_o !== w.reused) report("reused", reused_o, w.reused);
        if (granted_slot_o !== w.slot) report("granted_slot", granted_slot_o, w.slot);
        if (granted_buffer_o !== w.bufid) report("granted_buffer", granted_buffer_o, w.bufid);
        if (slot_offset_o !== w.offset) report("slot_offset", slot_offset_o, w.offset);
        if (rounded_size_o !== w.size) report("rounded_size", rounded_size_o, w.size);
      end
    end
  end

  task automatic send_item(logic m, logic [4:0] f, logic [12:0] rq, logic [11:0] si,
                           logic typed, alloc_res_t want);
    alloc_res_t p;
    start_i <= 1'b1;
    mode_i <= m;
    format_i <= f;
    request_size_i <= rq;
    slot_index_i <= si;
    do @(posedge clk_i); while (busy_o);
    p = predict_alloc(m, f, rq, si);
    pending_grants.push_back(typed ? want : p);
    items_sent++;
  endtask

  task automatic idle_gap();
    int unsigned k, n;
    k = $urandom_range(0, 99);
    n = (k < 55) ? 0 : (k < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_grants.size() != 0);
  endtask

  task automatic write_min_cap(logic [15:0] v);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    min_cap = v;
  endtask

  task automatic random_item(int unsigned fmt_lo, int unsigned fmt_hi);
    logic m;
    logic [4:0] f;
    logic [12:0] rq;
    logic [11:0] si;
    int unsigned k;
    k = $urandom_range(0, 99);
    m = (k < 30) ? REL : GET;
    f = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
        5'($urandom_range(fmt_lo, fmt_hi));
    k = $urandom_range(0, 99);
    rq = (k < 70) ? 13'($urandom_range(1, 256)) :
         (k < 90) ? 13'($urandom_range(0, 4096)) : 13'($urandom_range(0, 8191));
    si = (slots_carved > 0 && $urandom_range(0, 99) < 85) ?
         12'($urandom_range(0, slots_carved - 1)) : 12'($urandom_range(0, 4095));
    send_item(m, f, rq, si, 1'b0, '0);
    idle_gap();
  endtask

  stim_row_t directed [] = '{
    '{REL, 5'd0,  13'd0,    12'd0,    1'b1, '{StBadSlot, 1'b0, 12'd0, 5'd0, 16'd0, 13'd0}},
    '{GET, 5'd0,  13'd0,    12'd0,    1'b1, '{StBadSize, 1'b0, 12'd0, 5'd0, 16'd0, 13'd0}},
    '{GET, 5'd0,  13'd1,    12'd0,    1'b1, '{StOk, 1'b0, 12'd0, 5'd0, 16'd0, 13'd32}},
    '{GET, 5'd0,  13'd4096, 12'd0,    1'b0, '0},
    '{GET, 5'd0,  13'd4097, 12'd0,    1'b1, '{StBadSize, 1'b0, 12'd0, 5'd0, 16'd0, 13'd0}},
    '{GET, 5'd0,  13'd8191, 12'd0,    1'b1, '{StBadSize, 1'b0, 12'd0, 5'd0, 16'd0, 13'd0}},
    '{GET, 5'd18, 13'd32,   12'd0,    1'b1, '{StBadSize, 1'b0, 12'd0, 5'd0, 16'd0, 13'd0}},
    '{GET, 5'd31, 13'd32,   12'd4095, 1'b1, '{StBadSize, 1'b0, 12'd0, 5'd0, 16'd0, 13'd0}},
    '{GET, 5'd17, 13'd4096, 12'd0,    1'b0, '0},
    '{GET, 5'd0,  13'd4096, 12'd0,    1'b0, '0},
    '{REL, 5'd0,  13'd0,    12'd0,    1'b0, '0},
    '{REL, 5'd0,  13'd0,    12'd0,    1'b0, '0},
    '{GET, 5'd0,  13'd20,   12'd0,    1'b0, '0},
    '{GET, 5'd0,  13'd31,   12'd0,    1'b0, '0},
    '{GET, 5'd0,  13'd32,   12'd0,    1'b0, '0},
    '{REL, 5'd0,  13'd0,    12'd4095, 1'b1, '{StBadSlot, 1'b0, 12'd0, 5'd0, 16'd0, 13'd0}},
    '{REL, 5'd31, 13'd8191, 12'd2,    1'b0, '0},
    '{GET, 5'd17, 13'd4096, 12'd0,    1'b0, '0},
    '{GET, 5'd5,  13'd33,   12'd0,    1'b0, '0}
  };

  initial begin
    int unsigned i;
    foreach (free_head[j]) free_head[j] = NSLOT;
    foreach (fmt_newest[j]) fmt_newest[j] = NBUF;
    slots_carved = 0;
    bufs_opened = 0;
    min_cap = vsa_pkg::MinBufReset;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    foreach (status_hits[j]) status_hits[j] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy_o);

    foreach (directed[j]) begin
      send_item(directed[j].mode, directed[j].fmt, directed[j].req, directed[j].sidx,
                directed[j].typed, directed[j].res);
      idle_gap();
    end

    write_min_cap(16'd65535);
    for (i = 0; i < 450; i++) begin
      random_item(0, 9);
      if (i == 200) drain();
    end

    write_min_cap(16'd32);
    for (i = 0; i < 450; i++) random_item(10, NFMT - 1);

    for (i = 0; i < 150; i++) begin
      send_item(GET, 5'(i % 10), 13'd32, 12'd0, 1'b0, '0);
      if ($urandom_range(0, 19) == 0) idle_gap();
    end

    write_min_cap(16'($urandom_range(33, 65534)));
    for (i = 0; i < 80; i++) random_item(0, NFMT - 1);

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("Sent %0d items, checked %0d results against the allocator predictor.",
             items_sent, results_seen);
    $display("Status counts ok/size/slots/buffers/slot: %0d %0d %0d %0d %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("vertex_slot_allocator_core test passed");
    end else begin
      $display("vertex_slot_allocator_core test failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("vertex_slot_allocator_core test failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/vsa_pkg.sv
sv/vsa_ram.sv
sv/vertex_slot_allocator_core.sv
test/testbench.sv
